>>> design/lkrb_pkg.sv
// Shared types and constants for the layered keyboard report builder.
`default_nettype none

package lkrb_pkg;

    localparam int SLOT_FIELDS = 6;
    localparam int CNT_W       = 9;
    localparam int USED_W      = 3;

    localparam logic [7:0] ROLLOVER_CODE = 8'h01;
    localparam logic [4:0] MOD_PREFIX    = 5'b11100;

    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_DISC = 2'd1;
    localparam logic [1:0] KIND_MAP  = 2'd2;

    localparam logic [1:0] LAYER_BASE  = 2'd0;
    localparam logic [1:0] LAYER_UPPER = 2'd1;
    localparam logic [1:0] LAYER_TOP   = 2'd2;

    localparam logic [2:0] CFG_NORMAL   = 3'd0;
    localparam logic [2:0] CFG_ROLLOVER = 3'd1;
    localparam logic [2:0] CFG_MASTER   = 3'd2;
    localparam logic [2:0] CFG_SLAVE    = 3'd3;
    localparam logic [2:0] CFG_UPPER    = 3'd4;
    localparam logic [2:0] CFG_TOP      = 3'd5;
    localparam logic [2:0] CFG_FN       = 3'd6;

    typedef struct packed {
        logic       held;
        logic [7:0] code_top;
        logic [7:0] code_upper;
        logic [7:0] code_base;
    } key_entry_t;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic [7:0] code;
    } accum_ctl_t;

    typedef logic [SLOT_FIELDS-1:0][7:0] slot_arr_t;

endpackage

`default_nettype wire

>>> design/lkrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lkrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/lkrb_accum.sv
// Report accumulator: modifier byte, deduplicated key slots and overflow.
`default_nettype none

module lkrb_accum
    import lkrb_pkg::*;
#(
    parameter int REPORT_KEYS = 6
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire accum_ctl_t ctl,
    input  wire logic [7:0] upper_code,
    input  wire logic [7:0] top_code,
    input  wire logic [7:0] fn_code,
    input  wire logic       rollover_enable,
    output logic      [7:0] mods,
    output slot_arr_t       slots
);

    logic [7:0]        mods_reg, mods_next;
    slot_arr_t         slots_reg, slots_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic              over_reg, over_next;
    logic              reportable;
    logic              is_mod;
    logic              dup;

    always_comb
    begin
        reportable = (ctl.code != 8'd0) && (ctl.code != upper_code) &&
                     (ctl.code != top_code) && (ctl.code != fn_code);
        is_mod     = (ctl.code[7:3] == MOD_PREFIX);
        dup        = 1'b0;
        for (int k = 0; k < SLOT_FIELDS; k++)
        begin
            if ((USED_W'(k) < used_reg) && (slots_reg[k] == ctl.code))
            begin
                dup = 1'b1;
            end
        end

        mods_next  = mods_reg;
        slots_next = slots_reg;
        used_next  = used_reg;
        over_next  = over_reg;
        if (ctl.clear)
        begin
            mods_next  = '0;
            slots_next = '0;
            used_next  = '0;
            over_next  = 1'b0;
        end
        else if (ctl.push && reportable)
        begin
            if (is_mod)
            begin
                mods_next = mods_reg | (8'd1 << ctl.code[2:0]);
            end
            else if (!dup)
            begin
                if (used_reg < USED_W'(REPORT_KEYS))
                begin
                    for (int k = 0; k < SLOT_FIELDS; k++)
                    begin
                        if (USED_W'(k) == used_reg)
                        begin
                            slots_next[k] = ctl.code;
                        end
                    end
                    used_next = used_reg + USED_W'(1);
                end
                else
                begin
                    over_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            over_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            over_reg <= over_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mods_reg  <= mods_next;
        slots_reg <= slots_next;
    end

    always_comb
    begin
        mods = mods_reg;
        if (over_reg && rollover_enable)
        begin
            slots = {SLOT_FIELDS{ROLLOVER_CODE}};
        end
        else
        begin
            slots = slots_reg;
        end
    end

    used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(REPORT_KEYS))
        else $error("slot fill count beyond report width");

    over_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        over_reg |-> used_reg == USED_W'(REPORT_KEYS))
        else $error("overflow flagged before slots are full");

endmodule

`default_nettype wire

>>> design/layered_keyboard_report_builder_core.sv
// Top level: keymap/held-bit memory, item sequencer, scan and output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | kind, key_index, pressed, map_layer, map_code
//  out     | output    | out_valid/out_stall| modifier_bits, key_slot_0..key_slot_5
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A keymap write reads its entry, then writes it back. A report scan reads N
// keys, N being min(master_key_count + slave_key_count, KEY_SLOTS): one memory
// read per key. A key event updates its entry before its scan; a layer key
// release adds one more scan to look for another held key of the same layer.
// After reset a clearing pass zeroes all KEY_SLOTS entries before the first item.
// A stalled result holds in the output register while the next item runs.
`default_nettype none

module layered_keyboard_report_builder_core
    import lkrb_pkg::*;
#(
    parameter int KEY_SLOTS   = 128,
    parameter int REPORT_KEYS = 6
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [6:0] key_index,
    input  wire logic       pressed,
    input  wire logic [1:0] map_layer,
    input  wire logic [7:0] map_code,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] modifier_bits,
    output logic      [7:0] key_slot_0,
    output logic      [7:0] key_slot_1,
    output logic      [7:0] key_slot_2,
    output logic      [7:0] key_slot_3,
    output logic      [7:0] key_slot_4,
    output logic      [7:0] key_slot_5,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int KW = $clog2(KEY_SLOTS);
    localparam int CW = $clog2(KEY_SLOTS + 1);
    localparam int EW = $bits(key_entry_t);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // configuration
    logic       normal_mode_reg;
    logic       rollover_reg;
    logic [7:0] master_reg;
    logic [7:0] slave_reg;
    logic [7:0] upper_code_reg;
    logic [7:0] top_code_reg;
    logic [7:0] fn_code_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [KW-1:0] pend_addr_reg, pend_addr_next;
    logic          check_reg, check_next;
    logic          disc_reg, disc_next;
    logic          found_reg, found_next;
    logic          lay_sel_reg, lay_sel_next;
    logic          upper_on_reg, upper_on_next;
    logic          top_on_reg, top_on_next;
    logic          out_valid_reg, out_valid_next;

    // item payload
    logic [1:0]    it_kind_reg;
    logic [KW-1:0] it_idx_reg;
    logic          it_down_reg;
    logic [1:0]    it_layer_reg;
    logic [7:0]    it_code_reg;

    // result payload
    logic [7:0]    mod_out_reg;
    slot_arr_t     slot_out_reg;

    // memory ports
    logic          ram_we;
    logic [KW-1:0] ram_waddr;
    key_entry_t    ram_wdata;
    logic          ram_re;
    logic [KW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    key_entry_t    rd_entry;

    accum_ctl_t    acc_ctl;
    logic [7:0]    acc_mods;
    slot_arr_t     acc_slots;

    logic             in_accept;
    logic             range_ok;
    logic [CNT_W-1:0] key_sum;
    logic [CNT_W-1:0] scan_limit;
    logic             issue;
    logic [7:0]       active_code;
    logic [7:0]       lay_code;
    logic             clear_it;
    logic             load_out;

    lkrb_ram #(
        .WIDTH (EW),
        .DEPTH (KEY_SLOTS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lkrb_accum #(
        .REPORT_KEYS (REPORT_KEYS)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (acc_ctl),
        .upper_code      (upper_code_reg),
        .top_code        (top_code_reg),
        .fn_code         (fn_code_reg),
        .rollover_enable (rollover_reg),
        .mods            (acc_mods),
        .slots           (acc_slots)
    );

    assign rd_entry  = key_entry_t'(ram_rdata);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign range_ok  = (CNT_W'(key_index) < CNT_W'(KEY_SLOTS));
    assign key_sum   = CNT_W'(master_reg) + CNT_W'(slave_reg);
    assign scan_limit = (key_sum > CNT_W'(KEY_SLOTS)) ? CNT_W'(KEY_SLOTS) : key_sum;
    assign issue     = (CNT_W'(scan_idx_reg) < scan_limit);
    assign lay_code  = lay_sel_reg ? top_code_reg : upper_code_reg;
    assign clear_it  = disc_reg && (CNT_W'(pend_addr_reg) >= CNT_W'(master_reg));
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (top_on_reg)
        begin
            active_code = rd_entry.code_top;
        end
        else if (upper_on_reg)
        begin
            active_code = rd_entry.code_upper;
        end
        else
        begin
            active_code = rd_entry.code_base;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        check_next      = check_reg;
        disc_next       = disc_reg;
        found_next      = found_reg;
        lay_sel_next    = lay_sel_reg;
        upper_on_next   = upper_on_reg;
        top_on_next     = top_on_reg;
        out_valid_next  = out_valid_reg && out_stall;

        ram_we    = 1'b0;
        ram_waddr = it_idx_reg;
        ram_wdata = rd_entry;
        ram_re    = 1'b0;
        ram_raddr = KW'(key_index);

        acc_ctl.clear = 1'b0;
        acc_ctl.push  = 1'b0;
        acc_ctl.code  = active_code;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_idx_reg[KW-1:0];
                ram_wdata = '0;
                scan_idx_next = scan_idx_reg + CW'(1);
                if (scan_idx_reg == CW'(KEY_SLOTS - 1))
                begin
                    scan_idx_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (kind == KIND_DISC)
                    begin
                        acc_ctl.clear = 1'b1;
                        check_next    = 1'b0;
                        disc_next     = 1'b1;
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else if (range_ok && ((kind == KIND_MAP && map_layer != 2'd3) ||
                             (kind == KIND_KEY && normal_mode_reg)))
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                ram_we        = 1'b1;
                scan_idx_next = '0;
                found_next    = 1'b0;
                disc_next     = 1'b0;
                state_next    = ST_IDLE;
                if (it_kind_reg == KIND_MAP)
                begin
                    case (it_layer_reg)
                        LAYER_BASE:  ram_wdata.code_base  = it_code_reg;
                        LAYER_UPPER: ram_wdata.code_upper = it_code_reg;
                        LAYER_TOP:   ram_wdata.code_top   = it_code_reg;
                        default:     ram_wdata = rd_entry;
                    endcase
                end
                else
                begin
                    ram_wdata.held = it_down_reg;
                    if (active_code == upper_code_reg || active_code == top_code_reg)
                    begin
                        lay_sel_next = (active_code != upper_code_reg);
                        state_next   = ST_SCAN;
                        if (it_down_reg)
                        begin
                            // press turns the layer on and reports at once
                            if (active_code == upper_code_reg)
                            begin
                                upper_on_next = 1'b1;
                            end
                            else
                            begin
                                top_on_next = 1'b1;
                            end
                            acc_ctl.clear = 1'b1;
                            check_next    = 1'b0;
                        end
                        else
                        begin
                            check_next = 1'b1;
                        end
                    end
                    else if (active_code != fn_code_reg)
                    begin
                        acc_ctl.clear = 1'b1;
                        check_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_raddr = scan_idx_reg[KW-1:0];
                if (issue)
                begin
                    ram_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = scan_idx_reg[KW-1:0];
                    scan_idx_next   = scan_idx_reg + CW'(1);
                end
                if (pend_valid_reg)
                begin
                    if (check_reg)
                    begin
                        if (pend_addr_reg != it_idx_reg && rd_entry.held &&
                            rd_entry.code_base == lay_code)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_ctl.push = rd_entry.held && !clear_it;
                        if (clear_it)
                        begin
                            // drop the held bit of a key on the lost half
                            ram_we         = 1'b1;
                            ram_waddr      = pend_addr_reg;
                            ram_wdata.held = 1'b0;
                        end
                    end
                end
                if (!issue && !pend_valid_reg)
                begin
                    scan_idx_next = '0;
                    if (!check_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (found_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // no other key holds the layer: release it and report
                        if (lay_sel_reg)
                        begin
                            top_on_next = 1'b0;
                        end
                        else
                        begin
                            upper_on_next = 1'b0;
                        end
                        acc_ctl.clear = 1'b1;
                        check_next    = 1'b0;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            scan_idx_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            check_reg       <= 1'b0;
            disc_reg        <= 1'b0;
            found_reg       <= 1'b0;
            lay_sel_reg     <= 1'b0;
            upper_on_reg    <= 1'b0;
            top_on_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            normal_mode_reg <= 1'b1;
            rollover_reg    <= 1'b1;
            master_reg      <= 8'd64;
            slave_reg       <= 8'd64;
            upper_code_reg  <= 8'd240;
            top_code_reg    <= 8'd241;
            fn_code_reg     <= 8'd242;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
            check_reg      <= check_next;
            disc_reg       <= disc_next;
            found_reg      <= found_next;
            lay_sel_reg    <= lay_sel_next;
            upper_on_reg   <= upper_on_next;
            top_on_reg     <= top_on_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NORMAL:   normal_mode_reg <= cfg_data[0];
                    CFG_ROLLOVER: rollover_reg    <= cfg_data[0];
                    CFG_MASTER:   master_reg      <= cfg_data;
                    CFG_SLAVE:    slave_reg       <= cfg_data;
                    CFG_UPPER:    upper_code_reg  <= cfg_data;
                    CFG_TOP:      top_code_reg    <= cfg_data;
                    CFG_FN:       fn_code_reg     <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        if (in_accept)
        begin
            it_kind_reg  <= kind;
            it_idx_reg   <= KW'(key_index);
            it_down_reg  <= pressed;
            it_layer_reg <= map_layer;
            it_code_reg  <= map_code;
        end
        if (load_out)
        begin
            mod_out_reg  <= acc_mods;
            slot_out_reg <= acc_slots;
        end
    end

    assign out_valid     = out_valid_reg;
    assign modifier_bits = mod_out_reg;
    assign key_slot_0    = slot_out_reg[0];
    assign key_slot_1    = slot_out_reg[1];
    assign key_slot_2    = slot_out_reg[2];
    assign key_slot_3    = slot_out_reg[3];
    assign key_slot_4    = slot_out_reg[4];
    assign key_slot_5    = slot_out_reg[5];

    no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("memory read and write hit the same entry");

    scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && ram_re) |-> (CNT_W'(scan_idx_reg) < scan_limit))
        else $error("scan read past the key range");

    result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(mod_out_reg) &&
                                        $stable(slot_out_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

>>> tb/lkrb_report_checker.sv
// Channel monitor with a report predictor and field-by-field compare for the report builder.
`timescale 1ns / 1ps

module lkrb_report_checker
    import lkrb_pkg::*;
#(
    parameter int KEY_SLOTS   = 128,
    parameter int REPORT_KEYS = 6
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [6:0] key_index,
    input  wire logic       pressed,
    input  wire logic [1:0] map_layer,
    input  wire logic [7:0] map_code,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] modifier_bits,
    input  wire logic [7:0] key_slot_0,
    input  wire logic [7:0] key_slot_1,
    input  wire logic [7:0] key_slot_2,
    input  wire logic [7:0] key_slot_3,
    input  wire logic [7:0] key_slot_4,
    input  wire logic [7:0] key_slot_5,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output int              mismatch_count,
    output int              reports_pending
);

    typedef struct packed {
        logic [7:0] mods;
        slot_arr_t  slots;
    } report_t;

    logic       normal_mode;
    logic       rollover_on;
    logic [7:0] master_keys;
    logic [7:0] slave_keys;
    logic [7:0] upper_code;
    logic [7:0] top_code;
    logic [7:0] fn_code;

    logic       key_down  [KEY_SLOTS];
    logic [7:0] base_map  [KEY_SLOTS];
    logic [7:0] upper_map [KEY_SLOTS];
    logic [7:0] top_map   [KEY_SLOTS];
    logic       upper_on;
    logic       top_on;

    report_t    expected_reports [$];
    int         mismatches;

    function automatic int unsigned scan_len();
        int unsigned n;
        n = int'(master_keys) + int'(slave_keys);
        return (n > KEY_SLOTS) ? KEY_SLOTS : n;
    endfunction

    function automatic logic [7:0] layer_code(int unsigned k);
        if (top_on)
            return top_map[k];
        if (upper_on)
            return upper_map[k];
        return base_map[k];
    endfunction

    // Another held key whose base entry carries the same layer code keeps the layer on.
    function automatic logic keeps_layer(int unsigned k, logic [7:0] code);
        int unsigned i;
        for (i = 0; i < scan_len(); i++)
        begin
            if (i != k && base_map[i] == code && key_down[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic report_t build_report();
        report_t     rpt;
        int unsigned k;
        int unsigned s;
        int unsigned used;
        logic [7:0]  c;
        logic        dup;
        logic        over;
        rpt  = '0;
        used = 0;
        over = 1'b0;
        for (k = 0; k < scan_len(); k++)
        begin
            if (!key_down[k])
                continue;
            c = layer_code(k);
            if (c == 8'h00 || c == upper_code || c == top_code || c == fn_code)
                continue;
            if (c[7:3] == MOD_PREFIX)
            begin
                rpt.mods[c[2:0]] = 1'b1;
                continue;
            end
            dup = 1'b0;
            for (s = 0; s < used; s++)
            begin
                if (rpt.slots[s] == c)
                    dup = 1'b1;
            end
            if (dup)
                continue;
            if (used < REPORT_KEYS && used < SLOT_FIELDS)
            begin
                rpt.slots[used] = c;
                used++;
            end
            else
                over = 1'b1;
        end
        if (over && rollover_on)
        begin
            for (s = 0; s < SLOT_FIELDS; s++)
                rpt.slots[s] = ROLLOVER_CODE;
        end
        return rpt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        report_t     want;
        report_t     got;
        int unsigned j;
        logic [7:0]  code_now;
        if (!rst_n)
        begin
            normal_mode = 1'b1;
            rollover_on = 1'b1;
            master_keys = 8'd64;
            slave_keys  = 8'd64;
            upper_code  = 8'd240;
            top_code    = 8'd241;
            fn_code     = 8'd242;
            for (j = 0; j < KEY_SLOTS; j++)
            begin
                key_down[j]  = 1'b0;
                base_map[j]  = 8'h00;
                upper_map[j] = 8'h00;
                top_map[j]   = 8'h00;
            end
            upper_on = 1'b0;
            top_on   = 1'b0;
            expected_reports.delete();
            mismatches = 0;
            mismatch_count  <= 0;
            reports_pending <= 0;
        end
        else
        begin
            // Results first: an item accepted on this edge cannot have its report out yet.
            if (out_valid && !out_stall)
            begin
                got.mods  = modifier_bits;
                got.slots = {key_slot_5, key_slot_4, key_slot_3,
                             key_slot_2, key_slot_1, key_slot_0};
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: report with none expected: expected none, got mods %h slots %h",
                             $time, got.mods, got.slots);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.mods !== want.mods)
                    begin
                        $display("%0t: modifier_bits expected %h got %h",
                                 $time, want.mods, got.mods);
                        mismatches++;
                    end
                    for (j = 0; j < SLOT_FIELDS; j++)
                    begin
                        if (got.slots[j] !== want.slots[j])
                        begin
                            $display("%0t: key_slot_%0d expected %h got %h",
                                     $time, j, want.slots[j], got.slots[j]);
                            mismatches++;
                        end
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NORMAL:   normal_mode = cfg_data[0];
                    CFG_ROLLOVER: rollover_on = cfg_data[0];
                    CFG_MASTER:   master_keys = cfg_data;
                    CFG_SLAVE:    slave_keys  = cfg_data;
                    CFG_UPPER:    upper_code  = cfg_data;
                    CFG_TOP:      top_code    = cfg_data;
                    CFG_FN:       fn_code     = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                case (kind)
                    KIND_DISC:
                    begin
                        for (j = master_keys; j < scan_len(); j++)
                            key_down[j] = 1'b0;
                        expected_reports.push_back(build_report());
                    end
                    KIND_MAP:
                    begin
                        case (map_layer)
                            LAYER_BASE:  base_map[key_index]  = map_code;
                            LAYER_UPPER: upper_map[key_index] = map_code;
                            LAYER_TOP:   top_map[key_index]   = map_code;
                            default: ;
                        endcase
                    end
                    KIND_KEY:
                    begin
                        if (normal_mode)
                        begin
                            key_down[key_index] = pressed;
                            code_now = layer_code(key_index);
                            // Upper code wins when both layer codes match.
                            if (code_now == upper_code)
                            begin
                                if (pressed || !keeps_layer(key_index, upper_code))
                                begin
                                    upper_on = pressed;
                                    expected_reports.push_back(build_report());
                                end
                            end
                            else if (code_now == top_code)
                            begin
                                if (pressed || !keeps_layer(key_index, top_code))
                                begin
                                    top_on = pressed;
                                    expected_reports.push_back(build_report());
                                end
                            end
                            else if (code_now != fn_code)
                                expected_reports.push_back(build_report());
                        end
                    end
                    default: ;
                endcase
            end

            mismatch_count  <= mismatches;
            reports_pending <= expected_reports.size();
        end
    end

endmodule

>>> tb/layered_keyboard_report_builder_core_test.sv
// Stimulus, handshake pacing and verdict for the layered keyboard report builder.
`timescale 1ns / 1ps

module layered_keyboard_report_builder_core_test;
    import lkrb_pkg::*;

    localparam int KEY_SLOTS     = 128;
    localparam int REPORT_KEYS   = 6;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 450 / PHASES + 1;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1_500_000;

    // Field values the block must ignore.
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam logic [1:0] LAYER_SPARE = 2'd3;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    wire        in_stall;
    logic [1:0] kind      = KIND_KEY;
    logic [6:0] key_index = 7'd0;
    logic       pressed   = 1'b0;
    logic [1:0] map_layer = LAYER_BASE;
    logic [7:0] map_code  = 8'h00;
    wire        out_valid;
    logic       out_stall = 1'b0;
    wire  [7:0] modifier_bits;
    wire  [7:0] key_slot_0;
    wire  [7:0] key_slot_1;
    wire  [7:0] key_slot_2;
    wire  [7:0] key_slot_3;
    wire  [7:0] key_slot_4;
    wire  [7:0] key_slot_5;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_index = CFG_NORMAL;
    logic [7:0] cfg_data  = 8'h00;

    int         mismatch_count;
    int         reports_pending;

    int         send_idle_pct = 15;
    int         recv_idle_pct = 55;
    int         cycles        = 0;

    // Settings last written, and the keys this side believes are held.
    logic       set_normal = 1'b1;
    logic [7:0] set_master = 8'd64;
    logic [7:0] set_slave  = 8'd64;
    logic [7:0] set_upper  = 8'd240;
    logic [7:0] set_top    = 8'd241;
    logic [7:0] set_fn     = 8'd242;
    logic       held_now [KEY_SLOTS];

    layered_keyboard_report_builder_core #(
        .KEY_SLOTS   (KEY_SLOTS),
        .REPORT_KEYS (REPORT_KEYS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .key_index     (key_index),
        .pressed       (pressed),
        .map_layer     (map_layer),
        .map_code      (map_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .modifier_bits (modifier_bits),
        .key_slot_0    (key_slot_0),
        .key_slot_1    (key_slot_1),
        .key_slot_2    (key_slot_2),
        .key_slot_3    (key_slot_3),
        .key_slot_4    (key_slot_4),
        .key_slot_5    (key_slot_5),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lkrb_report_checker #(
        .KEY_SLOTS   (KEY_SLOTS),
        .REPORT_KEYS (REPORT_KEYS)
    ) report_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .key_index       (key_index),
        .pressed         (pressed),
        .map_layer       (map_layer),
        .map_code        (map_code),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .modifier_bits   (modifier_bits),
        .key_slot_0      (key_slot_0),
        .key_slot_1      (key_slot_1),
        .key_slot_2      (key_slot_2),
        .key_slot_3      (key_slot_3),
        .key_slot_4      (key_slot_4),
        .key_slot_5      (key_slot_5),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned scan_keys();
        int unsigned n;
        n = int'(set_master) + int'(set_slave);
        return (n > KEY_SLOTS) ? KEY_SLOTS : n;
    endfunction

    // Mostly ordinary usages, with modifiers, layer keys, FN, empty and raw bytes mixed in.
    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        logic [2:0] m;
        m = $urandom_range(7);
        case ($urandom_range(15))
            0:       c = 8'h00;
            1, 2:    c = {MOD_PREFIX, m};
            3:       c = set_upper;
            4:       c = set_top;
            5:       c = set_fn;
            6:       c = $urandom_range(255);
            default: c = $urandom_range(101, 4);
        endcase
        return c;
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [6:0] idx, input logic down,
                             input logic [1:0] lyr, input logic [7:0] code);
        int unsigned i;
        kind      <= k;
        key_index <= idx;
        pressed   <= down;
        map_layer <= lyr;
        map_code  <= code;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (k == KIND_KEY && set_normal)
            held_now[idx] = down;
        else if (k == KIND_DISC)
        begin
            for (i = set_master; i < scan_keys(); i++)
                held_now[i] = 1'b0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic key_event(input int idx, input logic down);
        send_item(KIND_KEY, idx, down, $urandom_range(3), $urandom);
    endtask

    // Drain all reports, then let a no-report item finish inside the block.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic nm, input logic ro, input logic [7:0] mc,
                                input logic [7:0] sc, input logic [7:0] uc,
                                input logic [7:0] tc, input logic [7:0] fc);
        logic [7:0] vals [7];
        logic [6:0] pad;
        int         r;
        pad = $urandom;
        vals[CFG_NORMAL] = {pad, nm};
        pad = $urandom;
        vals[CFG_ROLLOVER] = {pad, ro};
        vals[CFG_MASTER]   = mc;
        vals[CFG_SLAVE]    = sc;
        vals[CFG_UPPER]    = uc;
        vals[CFG_TOP]      = tc;
        vals[CFG_FN]       = fc;
        for (r = CFG_NORMAL; r <= CFG_FN; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_data  <= vals[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        set_normal = nm;
        set_master = mc;
        set_slave  = sc;
        set_upper  = uc;
        set_top    = tc;
        set_fn     = fc;
    endtask

    initial
    begin
        int          p;
        int          i;
        int          l;
        int          j;
        int          counted;
        int unsigned sel;
        int unsigned n_held;
        int unsigned scan;
        int unsigned start;
        logic [6:0]  idx;
        logic        down;
        logic [1:0]  lyr;
        logic [7:0]  code;
        logic        counts;

        for (i = 0; i < KEY_SLOTS; i++)
            held_now[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // Wait out the clearing pass before the first register write.
        repeat (SETTLE_CYCLES) @(posedge clk);
        program_regs(1'b1, 1'b1, 8'd64, 8'd64, 8'd240, 8'd241, 8'd242);

        // Fill every keymap entry; the low keys get fixed roles for the directed part.
        for (i = 0; i < KEY_SLOTS; i++)
        begin
            for (l = LAYER_BASE; l <= LAYER_TOP; l++)
            begin
                code = pick_code();
                if (l == LAYER_BASE)
                begin
                    case (i)
                        0:                          code = 8'h04;
                        1:                          code = 8'hE0;
                        2:                          code = 8'hE7;
                        3, 4:                       code = set_upper;
                        5:                          code = set_top;
                        6:                          code = set_fn;
                        7:                          code = 8'h00;
                        8, 9:                       code = 8'h05;
                        10, 11, 12, 13, 14, 15, 16: code = i - 4;
                        127:                        code = 8'hFF;
                        default: ;
                    endcase
                end
                else if (l == LAYER_UPPER && (i == 3 || i == 4))
                    code = set_upper;
                else if (l == LAYER_TOP && i == 5)
                    code = set_top;
                send_item(KIND_MAP, i, $urandom, l, code);
            end
        end

        // Plain key, both modifier extremes, then a duplicate usage.
        key_event(0, 1'b1);
        key_event(1, 1'b1);
        key_event(2, 1'b1);
        key_event(8, 1'b1);
        key_event(9, 1'b1);
        // Hold the upper layer with two keys; releasing the first keeps it on.
        key_event(3, 1'b1);
        key_event(10, 1'b1);
        key_event(4, 1'b1);
        key_event(3, 1'b0);
        key_event(4, 1'b0);
        // Top layer tap, FN key, empty code.
        key_event(5, 1'b1);
        key_event(5, 1'b0);
        key_event(6, 1'b1);
        key_event(7, 1'b1);
        // Push past six distinct usages for rollover.
        for (i = 11; i <= 16; i++)
            key_event(i, 1'b1);
        send_item(KIND_DISC, 7'h7F, 1'b1, LAYER_SPARE, 8'hFF);
        key_event(127, 1'b1);
        key_event(100, 1'b1);
        send_item(KIND_DISC, 7'h00, 1'b0, LAYER_BASE, 8'h00);
        send_item(KIND_SPARE, 7'h55, 1'b0, LAYER_UPPER, 8'hAA);
        send_item(KIND_MAP, 7'h2A, 1'b0, LAYER_SPARE, 8'h33);

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 15;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            case (p)
                0: program_regs(1'b1, 1'b1, 8'd64, 8'd64, 8'd240, 8'd241, 8'd242);
                1: program_regs(1'b1, 1'b0, 8'd0, 8'd128, 8'd240, 8'd241, 8'd242);
                2: program_regs(1'b1, 1'b1, 8'd128, 8'd128, 8'hFF, 8'h00, 8'h01);
                3: program_regs(1'b0, 1'b1, 8'd64, 8'd64, 8'd240, 8'd241, 8'd242);
                4: program_regs(1'b1, 1'b1, 8'd5, 8'd3, 8'd240, 8'd241, 8'd242);
                5: program_regs(1'b1, 1'b0, 8'd0, 8'd0, 8'h10, 8'h10, 8'hE2);
                6: program_regs(1'b1, 1'b1, 8'd100, 8'd28, 8'hF0, 8'hF1, 8'hF2);
                default: program_regs(1'b1, 1'b0, 8'd127, 8'd1, 8'hFF, 8'hFE, 8'h00);
            endcase

            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                sel    = $urandom_range(99);
                counts = 1'b1;
                if (sel < 62)
                begin
                    n_held = 0;
                    for (j = 0; j < KEY_SLOTS; j++)
                        n_held += held_now[j];
                    scan = scan_keys();
                    // Often release what is held; lean harder on release once many are down.
                    if (n_held != 0 && $urandom_range(99) < ((n_held > 9) ? 85 : 40))
                    begin
                        start = $urandom_range(KEY_SLOTS - 1);
                        idx   = start;
                        for (j = 0; j < KEY_SLOTS; j++)
                        begin
                            if (held_now[(start + j) % KEY_SLOTS])
                            begin
                                idx = (start + j) % KEY_SLOTS;
                                break;
                            end
                        end
                    end
                    else if (scan == 0 || $urandom_range(3) == 0)
                        idx = $urandom_range(KEY_SLOTS - 1);
                    else
                        idx = $urandom_range(scan - 1);
                    if ($urandom_range(99) < 8)
                        down = $urandom_range(1);
                    else
                        down = !held_now[idx];
                    counts = set_normal;
                    key_event(idx, down);
                end
                else if (sel < 72)
                    send_item(KIND_DISC, $urandom, $urandom, $urandom, $urandom);
                else if (sel < 92)
                begin
                    lyr    = $urandom_range(3);
                    counts = (lyr != LAYER_SPARE);
                    send_item(KIND_MAP, $urandom, $urandom, lyr, pick_code());
                end
                else
                begin
                    counts = 1'b0;
                    send_item(KIND_SPARE, $urandom, $urandom, $urandom, $urandom);
                end
                counted += counts;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
design/lkrb_pkg.sv
design/lkrb_ram.sv
design/lkrb_accum.sv
design/layered_keyboard_report_builder_core.sv
tb/lkrb_report_checker.sv
tb/layered_keyboard_report_builder_core_test.sv
